[rtl/hcc_pkg.sv]
`timescale 1ns / 1ps
// hcc_pkg: constants, state and command types for the hash combiner
// no dependencies; imported by hcc_ctrl, hcc_dp and the top level
package hcc_pkg;

	localparam logic [31:0] PRIME2 = 32'd2246822519;
	localparam logic [31:0] PRIME3 = 32'd3266489917;
	localparam logic [31:0] PRIME4 = 32'd668265263;
	localparam logic [31:0] PRIME5 = 32'd374761393;

	localparam int ROUND_ROT = 17;
	localparam int AVAL_SH1  = 15;
	localparam int AVAL_SH2  = 13;
	localparam int AVAL_SH3  = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_WORD,
		ST_MUL_ACC,
		ST_FIN1,
		ST_FIN2,
		ST_EMIT
	} hcc_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_WORD,
		OP_MUL_ACC,
		OP_FIN1,
		OP_FIN2,
		OP_EMIT
	} hcc_op_t;

	typedef struct packed {
		hcc_op_t op;
		logic    first;
	} hcc_cmd_t;

	typedef struct packed {
		logic out_free;
	} hcc_sts_t;

endpackage

[rtl/hcc_if.sv]
`timescale 1ns / 1ps
// hcc_in_if / hcc_out_if: valid-ready channels of the hash combiner
// no dependencies
interface hcc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	logic [7:0]  total_words;
	logic        last_word;

	modport source (output valid, output word, output total_words, output last_word,
		input ready);
	modport sink (input valid, input word, input total_words, input last_word,
		output ready);
endinterface

interface hcc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

[rtl/hcc_ctrl.sv]
`timescale 1ns / 1ps
// hcc_ctrl: sequencer for the hash combiner, one datapath step per state
// depends on hcc_pkg
module hcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  hcc_pkg::hcc_sts_t sts,
	output hcc_pkg::hcc_cmd_t cmd
);
	import hcc_pkg::*;

	hcc_state_t state_q, state_nxt;
	logic       in_msg_q;
	logic       last_q;
	logic       accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			in_msg_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				last_q   <= in_last;
				in_msg_q <= !in_last;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		cmd.first = !in_msg_q;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = ST_MUL_WORD;
				end
			end
			ST_MUL_WORD: begin
				cmd.op    = OP_MUL_WORD;
				state_nxt = ST_MUL_ACC;
			end
			ST_MUL_ACC: begin
				cmd.op    = OP_MUL_ACC;
				state_nxt = last_q ? ST_FIN1 : ST_IDLE;
			end
			ST_FIN1: begin
				cmd.op    = OP_FIN1;
				state_nxt = ST_FIN2;
			end
			ST_FIN2: begin
				cmd.op    = OP_FIN2;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.op    = OP_EMIT;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/hcc_dp.sv]
`timescale 1ns / 1ps
// hcc_dp: seed, accumulator, shared multiplier and output register
// depends on hcc_pkg
module hcc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	input  logic [31:0]       in_word,
	input  logic [7:0]        in_count,
	input  hcc_pkg::hcc_cmd_t cmd,
	output hcc_pkg::hcc_sts_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       out_hash
);
	import hcc_pkg::*;

	logic [31:0] seed_q;
	logic [31:0] acc_q;
	logic [31:0] word_q;
	logic [31:0] mul_q;
	logic [31:0] hash_q;
	logic        out_valid_q;

	logic [31:0] sum;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod;
	logic [31:0] start_val;

	assign sum       = acc_q + mul_q;
	assign start_val = seed_q + PRIME5 + {22'd0, in_count, 2'b00};

	always_comb begin
		case (cmd.op)
			OP_MUL_ACC: begin
				mul_a = (sum << ROUND_ROT) | (sum >> (32 - ROUND_ROT));
				mul_b = PRIME4;
			end
			OP_FIN1: begin
				mul_a = acc_q ^ (acc_q >> AVAL_SH1);
				mul_b = PRIME2;
			end
			OP_FIN2: begin
				mul_a = mul_q ^ (mul_q >> AVAL_SH2);
				mul_b = PRIME3;
			end
			default: begin
				mul_a = word_q;
				mul_b = PRIME3;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= 32'd0;
			acc_q       <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (cmd.op == OP_LOAD && cmd.first) begin
				acc_q <= start_val;
			end else if (cmd.op == OP_MUL_ACC) begin
				acc_q <= prod;
			end
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			word_q <= in_word;
		end
		if (cmd.op == OP_MUL_WORD || cmd.op == OP_FIN1 || cmd.op == OP_FIN2) begin
			mul_q <= prod;
		end
		if (cmd.op == OP_EMIT) begin
			hash_q <= mul_q ^ (mul_q >> AVAL_SH3);
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_hash     = hash_q;

endmodule

[rtl/hash_code_combine.sv]
`timescale 1ns / 1ps
// hash_code_combine: top level of the 32-bit word hash combiner
// depends on hcc_pkg, hcc_if, hcc_ctrl and hcc_dp
//
// folds a message of 32-bit words into one xxhash32-style hash. the first
// beat of a message starts the accumulator at seed + prime5 + 4 * total_words
// (total_words is only looked at on that beat), every beat then runs one
// round: multiply by prime3, add, rotate left 17, multiply by prime4. the beat
// with last_word set also runs the avalanche finaliser and one hash_value beat
// leaves on the output channel; other beats give nothing. a word that is not
// last goes through load, word multiply and accumulator multiply before the
// next ready; a last word then also runs two finaliser multiplies and the
// load of the output register, which waits while that register is still
// held by an earlier hash. all multiplies share one 32x32 unit, so the block
// takes no new word before the last one is through. the output register lets
// a new message start while a finished hash still waits to be taken. the seed
// is written by cfg_we/cfg_wdata, resets to 0 and is sampled on each first
// beat, so a write during a message only affects the next one.
module hash_code_combine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	hcc_in_if.sink      in_ch,
	hcc_out_if.source   out_ch
);
	import hcc_pkg::*;

	hcc_cmd_t cmd;
	hcc_sts_t sts;
	logic     in_ready;
	logic     out_valid;
	logic [31:0] out_hash;

	// sequencer: owns the message flag and the step order
	hcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_last  (in_ch.last_word),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: seed register, accumulator, shared multiplier, output register
	hcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_word   (in_ch.word),
		.in_count  (in_ch.total_words),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.out_hash  (out_hash)
	);

	assign in_ch.ready       = in_ready;
	assign out_ch.valid      = out_valid;
	assign out_ch.hash_value = out_hash;

endmodule

[rtl/hcc_checker.sv]
`timescale 1ns / 1ps
// hcc_checker: port-level assertions for hash_code_combine, bound to the top
// depends on hash_code_combine and hcc_if
module hcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_hash
);

	// every beat keeps the input closed through the word and accumulator multiplies
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input reopened during a round");

	// a last beat still has the input closed in the second finaliser step
	a_busy_final: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> ##3 !in_ready)
		else $error("input reopened during finaliser");

	// a new hash only appears out of a busy cycle
	a_rise_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("hash appeared without a finished message");

	// a waiting hash holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hash))
		else $error("waiting hash changed");

endmodule

bind hash_code_combine hcc_checker u_hcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_last   (in_ch.last_word),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_hash  (out_ch.hash_value)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for hash_code_combine, with its own hash predictor
// depends on hcc_pkg (primes, shift amounts), hcc_if channels and the rtl of the block
module testbench;
	import hcc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 500_000;
	// settle time after valid drops: longer than a word still in flight, last word included, keeps the block busy
	localparam int unsigned IDLE_SETTLE  = 12;

	// predictor and store of hashes still owed by the block
	class hash_scoreboard;
		logic [31:0] seed;
		logic [31:0] acc;
		bit          open;
		logic [31:0] owed_hashes[$];
		int unsigned errors;

		function new();
			seed   = '0;
			acc    = '0;
			open   = 1'b0;
			errors = 0;
		endfunction

		// one round: add word times prime3, rotate left, times prime4
		function logic [31:0] fold_round(logic [31:0] a, logic [31:0] w);
			logic [31:0] t;
			t = a + w * PRIME3;
			t = (t << ROUND_ROT) | (t >> (32 - ROUND_ROT));
			return t * PRIME4;
		endfunction

		function logic [31:0] avalanche(logic [31:0] h);
			logic [31:0] v;
			v = h ^ (h >> AVAL_SH1);
			v = v * PRIME2;
			v = v ^ (v >> AVAL_SH2);
			v = v * PRIME3;
			return v ^ (v >> AVAL_SH3);
		endfunction

		function void set_seed(logic [31:0] v);
			seed = v;
		endfunction

		function int unsigned pending();
			return owed_hashes.size();
		endfunction

		// an input beat was taken by the block
		function void note_word(logic [31:0] w, logic [7:0] n, logic l);
			// count and seed only matter on the opening word of a message
			if (!open)
				acc = seed + PRIME5 + {22'd0, n, 2'b00};
			acc = fold_round(acc, w);
			if (l) begin
				owed_hashes = {owed_hashes, avalanche(acc)};
				open = 1'b0;
			end else begin
				open = 1'b1;
			end
		endfunction

		// an output beat left the block
		function void check_hash(logic [31:0] actual);
			logic [31:0] want;
			if (owed_hashes.size() == 0) begin
				$display("%0t: hash_value expected none, actual %08h", $time, actual);
				errors++;
			end else begin
				want = owed_hashes.pop_front();
				if (want !== actual) begin
					$display("%0t: hash_value expected %08h, actual %08h", $time, want, actual);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	hcc_in_if  in_ch();
	hcc_out_if out_ch();

	hash_code_combine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	hash_scoreboard board = new();

	// per-cycle odds, in percent, of the sender holding back and the receiver stalling
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned cycle_count   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: ready redrawn every cycle, steady high when stalls are off
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watch both channels at the edge; values read here are those the block sampled
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				board.check_hash(out_ch.hash_value);
			if (in_ch.valid && in_ch.ready)
				board.note_word(in_ch.word, in_ch.total_words, in_ch.last_word);
		end
		cycle_count++;
		// hang guard: far beyond the slowest correct run
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// present one beat, with random idle cycles ahead of it, and hold it until taken;
	// valid stays high afterwards so back-to-back beats need no second assignment
	task automatic send_word(input logic [31:0] w, input logic [7:0] n, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.word        <= w;
		in_ch.total_words <= n;
		in_ch.last_word   <= l;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// drop valid, let a word still in flight finish, then let every owed hash come out
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		repeat (IDLE_SETTLE) @(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// seed write; only ever called with the block idle
	task automatic write_seed(input logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_seed(v);
	endtask

	// random messages under one idling mix until about the given number of beats
	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall,
		input int unsigned beats);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		logic [7:0]  count;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		sent          = 0;
		while (sent < beats) begin
			// mostly short messages, now and then a long one
			pick = $urandom_range(99);
			if (pick < 60)
				len = $urandom_range(4, 1);
			else if (pick < 90)
				len = $urandom_range(12, 5);
			else
				len = $urandom_range(48, 13);
			// most counts match the message, the rest are arbitrary (zero included)
			count = ($urandom_range(99) < 15) ? 8'($urandom_range(255)) : 8'(len);
			// later beats carry junk counts that the block must ignore
			for (int unsigned i = 0; i < len; i++)
				send_word($urandom(), (i == 0) ? count : 8'($urandom_range(255)),
					i == len - 1);
			sent += len;
			// occasional full drain before the next message
			if ($urandom_range(99) < 3)
				wait_idle();
		end
		wait_idle();
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		in_ch.valid       <= 1'b0;
		in_ch.word        <= '0;
		in_ch.total_words <= '0;
		in_ch.last_word   <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset seed of zero first
		send_word(32'h0000_0000, 8'd1, 1'b1);     // single word, all zero
		send_word(32'hFFFF_FFFF, 8'd255, 1'b1);   // single word, top values
		send_word(32'hA5A5_5A5A, 8'd0, 1'b1);     // zero count
		// count says two, four words arrive; later counts vary
		send_word(32'h8000_0001, 8'd2, 1'b0);
		send_word(32'h7FFF_FFFE, 8'hFF, 1'b0);
		send_word(32'h0000_FFFF, 8'h00, 1'b0);
		send_word(32'hFFFF_0000, 8'hAA, 1'b1);
		wait_idle();
		write_seed(32'hFFFF_FFFF);
		send_word(32'h1357_9BDF, 8'd3, 1'b0);
		send_word(32'h2468_ACE0, 8'h55, 1'b0);
		send_word(32'hDEAD_BEEF, 8'hFF, 1'b1);
		// seed written in the middle of a message only counts from the next one
		send_word(32'h0F0F_0F0F, 8'd4, 1'b0);
		send_word(32'hF0F0_F0F0, 8'd4, 1'b0);
		wait_idle();
		write_seed(32'h1234_5678);
		send_word(32'h3C3C_C3C3, 8'd9, 1'b0);
		send_word(32'hC3C3_3C3C, 8'd1, 1'b1);
		send_word(32'h0000_0001, 8'd1, 1'b1);     // first message under the new seed
		wait_idle();

		// random part: one seed per idling mix, extremes among them
		write_seed(32'h0000_0000);
		run_phase(0, 0, 330);
		write_seed(32'hFFFF_FFFF);
		run_phase(76, 0, 330);
		write_seed($urandom());
		run_phase(0, 76, 330);
		write_seed($urandom());
		run_phase(31, 31, 330);

		// run_phase has drained and settled; a stray late beat would have been caught
		if (board.errors == 0 && board.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
